### design/accel_window_dead_reckoning_top_assert.svh
// Assertion macros for the block's back end (awdr_back).
// Macros expect clk (and rst for AWDR_ASSERT) in the using scope.
`ifndef ACCEL_WINDOW_DEAD_RECKONING_TOP_ASSERT_SVH
`define ACCEL_WINDOW_DEAD_RECKONING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AWDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("awdr assertion failed");
`define AWDR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("awdr check failed");
`else
`define AWDR_ASSERT(lbl, prop)
`define AWDR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/awdr_pkg.sv
package awdr_pkg;

  // field widths
  localparam int ACC_W      = 13;
  localparam int SMP_W      = 14;
  localparam int SUM_W      = 18;
  localparam int DT_W       = 16;
  localparam int REG_W      = 48;
  localparam int GRAV_W     = 11;
  localparam int LIM_W      = 4;
  localparam int WIN_W      = 3 * SMP_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // constant divider sizing: dividend magnitude, divisor, digit, reciprocal
  localparam int DVD_W = 64;
  localparam int DVS_W = 18;
  localparam int DIG_W = 16;
  localparam int RCP_W = 24;

  // input queue
  localparam int Q_DEPTH = 2;

  // config register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL   = 8'd1;
  localparam logic [GRAV_W-1:0]    GRAV_RESET  = 11'd980;
  localparam logic [LIM_W-1:0]     LIM_RESET   = 4'd10;

  // position step divides by 2 * 1000 ms
  localparam logic [DVS_W-1:0] POS_DIVISOR = 18'd2000;
  // floor(2^(DVS_W+DIG_W) / divisor), used per quotient digit
  localparam logic [RCP_W-1:0] POS_RECIP   = RCP_W'((64'd1 << (DVS_W + DIG_W)) / 2000);

  typedef struct packed {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] z;
    logic [DT_W-1:0]         dt;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_MUL1,
    B_DIV1,
    B_WAIT1,
    B_VEL,
    B_MUL2,
    B_DIV2,
    B_WAIT2,
    B_DONE
  } back_state_t;

endpackage

### design/awdr_ram.sv
module awdr_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/awdr_div.sv
module awdr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [awdr_pkg::DVD_W-1:0]  dividend,
  input  logic [awdr_pkg::DVS_W-1:0]  divisor,
  input  logic [awdr_pkg::RCP_W-1:0]  recip,
  output logic                        done,
  output logic [awdr_pkg::DVD_W-1:0]  quotient,
  output logic                        rem_nz
);
  import awdr_pkg::*;

  // 16-bit digits, each in two steps: reciprocal estimate, then correction
  localparam int NUM_DIG = DVD_W / DIG_W;
  localparam int T_W     = DVS_W + DIG_W;
  localparam int P_W     = T_W + RCP_W;
  localparam int R_W     = DVS_W + 1;
  localparam int CNT_W   = $clog2(2 * NUM_DIG);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2 * NUM_DIG - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [T_W-1:0]   t_cur;
  logic [T_W-1:0]   t_r;
  logic [P_W-1:0]   est_prod;
  logic [DIG_W-1:0] q_est;
  logic [T_W-1:0]   qc;
  logic [R_W-1:0]   r_est;
  logic             ge;
  logic [R_W-1:0]   r_fix;
  logic [DIG_W-1:0] q_dig;

  // partial dividend, estimate low by at most one, fix with one compare
  always_comb begin
    t_cur = {rem, quo[DVD_W-1 -: DIG_W]};
    q_est = est_prod[T_W +: DIG_W];
    qc    = T_W'(q_est) * T_W'(divisor);
    r_est = t_r[R_W-1:0] - qc[R_W-1:0];
    ge    = r_est >= {1'b0, divisor};
    r_fix = ge ? r_est - {1'b0, divisor} : r_est;
    q_dig = q_est + DIG_W'(ge);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, estimate and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!cnt[0]) begin
        t_r      <= t_cur;
        est_prod <= P_W'(t_cur) * P_W'(recip);
      end else begin
        rem <= r_fix[DVS_W-1:0];
        quo <= {quo[DVD_W-DIG_W-1:0], q_dig};
      end
    end
  end

  assign quotient = quo;
  assign rem_nz   = |rem;

endmodule

### design/awdr_front.sv
module awdr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [awdr_pkg::ACC_W-1:0]  accel_x,
  input  logic signed [awdr_pkg::ACC_W-1:0]  accel_y,
  input  logic signed [awdr_pkg::ACC_W-1:0]  accel_z,
  input  logic [awdr_pkg::DT_W-1:0]          elapsed_ms,
  input  logic [awdr_pkg::GRAV_W-1:0]        gravity_offset,
  output awdr_pkg::item_t                    q_item,
  output logic                               q_valid,
  input  logic                               q_pop
);
  import awdr_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);

  item_t            entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  item_t            new_item;

  // sign-extend, z = gravity_offset - accel_z
  always_comb begin
    new_item.x  = SMP_W'(accel_x);
    new_item.y  = SMP_W'(accel_y);
    new_item.z  = $signed({3'b000, gravity_offset}) - SMP_W'(accel_z);
    new_item.dt = elapsed_ms;
  end

  assign full    = count == FULL_CNT;
  assign q_valid = count != '0;
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= new_item;
    end
  end

endmodule

### design/awdr_back.sv
`include "accel_window_dead_reckoning_top_assert.svh"
module awdr_back #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  awdr_pkg::item_t                    q_item,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  logic [awdr_pkg::LIM_W-1:0]         still_limit,
  output logic                               out_valid,
  input  logic                               out_pop,
  output logic signed [awdr_pkg::SUM_W-1:0]  window_sum_x,
  output logic signed [awdr_pkg::SUM_W-1:0]  window_sum_y,
  output logic signed [awdr_pkg::SUM_W-1:0]  window_sum_z,
  output logic signed [awdr_pkg::REG_W-1:0]  velocity_x,
  output logic signed [awdr_pkg::REG_W-1:0]  velocity_y,
  output logic signed [awdr_pkg::REG_W-1:0]  velocity_z,
  output logic signed [awdr_pkg::REG_W-1:0]  position_x,
  output logic signed [awdr_pkg::REG_W-1:0]  position_y,
  output logic signed [awdr_pkg::REG_W-1:0]  position_z,
  output logic [awdr_pkg::REG_W-1:0]         path_length
);
  import awdr_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [DVS_W-1:0] INC_DIVISOR = DVS_W'(WINDOW_DEPTH * 1000);
  localparam logic [RCP_W-1:0] INC_RECIP =
    RCP_W'((64'd1 << (DVS_W + DIG_W)) / (WINDOW_DEPTH * 1000));
  localparam int MUL1_W = SUM_W + DT_W;
  localparam int PP_LO_W = 32;
  localparam int MUL2_LO_W = PP_LO_W + DT_W;
  localparam int PP_HI_W = DVD_W - PP_LO_W;

  back_state_t state;
  back_state_t state_next;

  item_t                    cur;
  logic [SLOT_W-1:0]        slot;
  logic [WINDOW_DEPTH-1:0]  slot_valid;
  logic [WIN_W-1:0]         rd_data;
  logic                     rd_en;
  logic                     wr_en;
  logic                     div_start;
  logic [DVS_W-1:0]         divisor;
  logic [RCP_W-1:0]         recip;

  logic signed [SUM_W-1:0]  run_sum  [3];
  logic signed [REG_W-1:0]  vel      [3];
  logic signed [REG_W-1:0]  prev_v   [3];
  logic signed [REG_W-1:0]  pos      [3];
  logic [REG_W-1:0]         travelled;
  logic [LIM_W-1:0]         still_count;
  logic                     neg      [3];
  logic [DVD_W-1:0]         prod     [3];
  logic [PP_HI_W-1:0]       pp_hi    [3];

  logic signed [SMP_W-1:0]  smp      [3];
  logic signed [SMP_W-1:0]  old      [3];
  logic signed [SUM_W-1:0]  sum_next [3];
  logic [SUM_W-1:0]         abs_sum  [3];
  logic [MUL1_W-1:0]        mul1     [3];
  logic [REG_W-1:0]         incm     [3];
  logic signed [REG_W-1:0]  vel_inc  [3];
  logic signed [REG_W:0]    vsum     [3];
  logic [REG_W:0]           abs_s    [3];
  logic [MUL2_LO_W-1:0]     mul2_lo  [3];
  logic [PP_HI_W-1:0]       mul2_hi  [3];
  logic [DVD_W-1:0]         dvd      [3];
  logic [REG_W-1:0]         mag      [3];
  logic signed [REG_W-1:0]  pos_next [3];
  logic [REG_W-1:0]         trav_next;
  logic                     is_still;
  logic                     zero_v;
  logic [LIM_W-1:0]         still_next;

  logic                     div_done [3];
  logic [DVD_W-1:0]         quo      [3];
  logic                     rnz      [3];

  // sample window memory
  awdr_ram #(
    .WIDTH (WIN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata ({cur.z, cur.y, cur.x}),
    .re    (rd_en),
    .raddr (slot),
    .rdata (rd_data)
  );

  // one constant divider lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    awdr_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd[g]),
      .divisor  (divisor),
      .recip    (recip),
      .done     (div_done[g]),
      .quotient (quo[g]),
      .rem_nz   (rnz[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid && !out_valid) state_next = B_READ;
      B_READ:  state_next = B_MUL1;
      B_MUL1:  state_next = B_DIV1;
      B_DIV1:  state_next = B_WAIT1;
      B_WAIT1: if (div_done[0]) state_next = B_VEL;
      B_VEL:   state_next = B_MUL2;
      B_MUL2:  state_next = B_DIV2;
      B_DIV2:  state_next = B_WAIT2;
      B_WAIT2: if (div_done[0]) state_next = B_DONE;
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    divisor   = INC_DIVISOR;
    recip     = INC_RECIP;
    case (state)
      B_IDLE: begin
        q_pop = q_valid && !out_valid;
        rd_en = q_valid && !out_valid;
      end
      B_READ:  wr_en = 1'b1;
      B_DIV1:  div_start = 1'b1;
      B_DIV2: begin
        div_start = 1'b1;
        divisor   = POS_DIVISOR;
        recip     = POS_RECIP;
      end
      B_WAIT2: begin
        divisor = POS_DIVISOR;
        recip   = POS_RECIP;
      end
      default: ;
    endcase
  end

  // per-axis datapath
  always_comb begin
    smp[0] = cur.x;
    smp[1] = cur.y;
    smp[2] = cur.z;
    for (int i = 0; i < 3; i++) begin
      old[i]      = slot_valid[slot] ? $signed(rd_data[i*SMP_W +: SMP_W]) : '0;
      sum_next[i] = run_sum[i] + SUM_W'(smp[i]) - SUM_W'(old[i]);
      abs_sum[i]  = run_sum[i][SUM_W-1] ? SUM_W'(-run_sum[i]) : SUM_W'(run_sum[i]);
      mul1[i]     = MUL1_W'(abs_sum[i]) * MUL1_W'(cur.dt);
      // floor on the magnitude: round away when negative with remainder
      incm[i]     = quo[i][REG_W-1:0] + REG_W'(neg[i] && rnz[i]);
      vel_inc[i]  = neg[i] ? vel[i] - $signed(incm[i]) : vel[i] + $signed(incm[i]);
      vsum[i]     = {vel[i][REG_W-1], vel[i]} + {prev_v[i][REG_W-1], prev_v[i]};
      abs_s[i]    = vsum[i][REG_W] ? (REG_W+1)'(-vsum[i]) : (REG_W+1)'(vsum[i]);
      // |vsum| * dt as two partial products, joined at the divider input
      mul2_lo[i]  = MUL2_LO_W'(abs_s[i][PP_LO_W-1:0]) * MUL2_LO_W'(cur.dt);
      mul2_hi[i]  = PP_HI_W'(abs_s[i][REG_W:PP_LO_W]) * PP_HI_W'(cur.dt);
      dvd[i]      = prod[i] + {pp_hi[i], {PP_LO_W{1'b0}}};
      mag[i]      = quo[i][REG_W-1:0] + REG_W'(neg[i] && rnz[i]);
      pos_next[i] = neg[i] ? pos[i] - $signed(mag[i]) : pos[i] + $signed(mag[i]);
    end
    trav_next = travelled + mag[0] + mag[1] + mag[2];
  end

  // still detection on x and y increments
  always_comb begin
    is_still   = (incm[0] == '0) && (incm[1] == '0);
    zero_v     = is_still && (still_count == still_limit);
    still_next = '0;
    if (is_still) begin
      still_next = zero_v ? LIM_W'(1) : still_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // architectural state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      slot_valid  <= '0;
      travelled   <= '0;
      still_count <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_sum[i] <= '0;
        vel[i]     <= '0;
        pos[i]     <= '0;
      end
    end else begin
      if (out_valid && out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_READ: begin
          for (int i = 0; i < 3; i++) begin
            run_sum[i] <= sum_next[i];
          end
          slot_valid[slot] <= 1'b1;
          slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        end
        B_VEL: begin
          for (int i = 0; i < 3; i++) begin
            vel[i] <= zero_v ? '0 : vel_inc[i];
          end
          still_count <= still_next;
        end
        B_DONE: begin
          for (int i = 0; i < 3; i++) begin
            pos[i] <= pos_next[i];
          end
          travelled <= trav_next;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (q_pop) cur <= q_item;
      B_MUL1: begin
        for (int i = 0; i < 3; i++) begin
          neg[i]   <= run_sum[i][SUM_W-1];
          prod[i]  <= DVD_W'({mul1[i], 16'd0});
          pp_hi[i] <= '0;
        end
      end
      B_VEL: begin
        for (int i = 0; i < 3; i++) begin
          prev_v[i] <= vel[i];
        end
      end
      B_MUL2: begin
        for (int i = 0; i < 3; i++) begin
          neg[i]   <= vsum[i][REG_W];
          prod[i]  <= DVD_W'(mul2_lo[i]);
          pp_hi[i] <= mul2_hi[i];
        end
      end
      default: ;
    endcase
  end

  assign window_sum_x = run_sum[0];
  assign window_sum_y = run_sum[1];
  assign window_sum_z = run_sum[2];
  assign velocity_x   = vel[0];
  assign velocity_y   = vel[1];
  assign velocity_z   = vel[2];
  assign position_x   = pos[0];
  assign position_y   = pos[1];
  assign position_z   = pos[2];
  assign path_length  = travelled;

  `AWDR_ASSERT(a_slot_range, slot <= LAST_SLOT)
  `AWDR_ASSERT(a_lanes_sync, (div_done[0] == div_done[1]) && (div_done[1] == div_done[2]))
  `AWDR_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state) == B_DONE)

endmodule

### design/accel_window_dead_reckoning_top.sv
// Dead reckoning from three-axis acceleration with a moving-average window.
// Input channel: push/full. A transaction carries accel_x/y/z and elapsed_ms
// and is taken when push is high and full is low; a two-entry queue holds
// gravity-compensated samples until the back end is free.
// Result channel: empty/pop. While empty is low the window sums, velocities,
// positions and path length after the latest sample are on the ports; the
// transaction completes when pop is high and empty is low.
// Config channel: cfg_valid/cfg_ready, always ready. Index 0 sets
// gravity_offset, index 1 sets still_limit, other indexes are ignored.
// The back end takes a sample from the queue only when idle with no result
// waiting, and finishes it before taking the next. Two passes of three
// parallel constant dividers (four 16-bit digits, a reciprocal multiply and
// a correction per digit) compute each result: velocity step, then position.
// Reset clears the window (valid bits per slot), all accumulators and the
// still counter, and restores gravity_offset 980 and still_limit 10.
// While a result waits unpopped the back end holds; samples keep queuing
// until the input queue fills and full rises.
module accel_window_dead_reckoning_top #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [awdr_pkg::ACC_W-1:0]      accel_x,
  input  logic signed [awdr_pkg::ACC_W-1:0]      accel_y,
  input  logic signed [awdr_pkg::ACC_W-1:0]      accel_z,
  input  logic [awdr_pkg::DT_W-1:0]              elapsed_ms,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [awdr_pkg::SUM_W-1:0]      window_sum_x,
  output logic signed [awdr_pkg::SUM_W-1:0]      window_sum_y,
  output logic signed [awdr_pkg::SUM_W-1:0]      window_sum_z,
  output logic signed [awdr_pkg::REG_W-1:0]      velocity_x,
  output logic signed [awdr_pkg::REG_W-1:0]      velocity_y,
  output logic signed [awdr_pkg::REG_W-1:0]      velocity_z,
  output logic signed [awdr_pkg::REG_W-1:0]      position_x,
  output logic signed [awdr_pkg::REG_W-1:0]      position_y,
  output logic signed [awdr_pkg::REG_W-1:0]      position_z,
  output logic [awdr_pkg::REG_W-1:0]             path_length,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [awdr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [awdr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import awdr_pkg::*;

  logic [GRAV_W-1:0] gravity_offset;
  logic [LIM_W-1:0]  still_limit;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  logic              out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_offset <= GRAV_RESET;
      still_limit    <= LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAVITY: gravity_offset <= cfg_data[GRAV_W-1:0];
        CFG_STILL:   still_limit    <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  awdr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .elapsed_ms     (elapsed_ms),
    .gravity_offset (gravity_offset),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  awdr_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .still_limit  (still_limit),
    .out_valid    (out_valid),
    .out_pop      (pop),
    .window_sum_x (window_sum_x),
    .window_sum_y (window_sum_y),
    .window_sum_z (window_sum_z),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .velocity_z   (velocity_z),
    .position_x   (position_x),
    .position_y   (position_y),
    .position_z   (position_z),
    .path_length  (path_length)
  );

endmodule
